>>> rtl/core/sha256sh_pkg.sv
// shared types, constants and round table of the sha-256 stream hasher
package sha256sh_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_t;

	typedef logic [7:0][31:0]  words8_t;
	typedef logic [15:0][31:0] words16_t;

	typedef struct packed {
		logic        load;
		logic [31:0] word;
		logic        start;
		logic        reinit;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] LAST_FILL  = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [2:0] LAST_IDX   = 3'd7;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

>>> rtl/core/sha256sh_round.sv
// one sha-256 round with its message schedule step
module sha256sh_round (
	input  sha256sh_pkg::words8_t  vars,
	input  sha256sh_pkg::words16_t win,
	input  logic                   sched_msg,
	input  logic [31:0]            k,
	output sha256sh_pkg::words8_t  vars_nxt,
	output logic [31:0]            wt
);
	import sha256sh_pkg::*;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	logic [31:0] lo0, lo1, s0, s1, ch, maj, t1, t2;

	always_comb begin
		lo0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
		lo1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
		wt  = sched_msg ? win[0] : (win[0] + lo0 + win[9] + lo1);
		s1  = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
		ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
		t1  = vars[7] + s1 + ch + k + wt;
		s0  = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
		maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
		t2  = s0 + maj;
		vars_nxt[7] = vars[6];
		vars_nxt[6] = vars[5];
		vars_nxt[5] = vars[4];
		vars_nxt[4] = vars[3] + t1;
		vars_nxt[3] = vars[2];
		vars_nxt[2] = vars[1];
		vars_nxt[1] = vars[0];
		vars_nxt[0] = t1 + t2;
	end

endmodule

>>> rtl/core/sha256sh_core.sv
// compression engine: schedule window, working variables, round counter and chaining words
module sha256sh_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sha256sh_pkg::core_ctl_t ctl,
	output sha256sh_pkg::core_sts_t sts,
	output sha256sh_pkg::words8_t   chain
);
	import sha256sh_pkg::*;

	logic [31:0] win_q [16];
	logic [31:0] chain_q [8];
	words8_t     vars_q;
	words8_t     vars_nxt;
	words16_t    win_w;
	logic [31:0] wt;
	logic [5:0]  round_q;
	logic        busy_q;
	logic        add_q;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			win_w[i] = win_q[i];
		end
		for (int i = 0; i < 8; i++) begin
			chain[i] = chain_q[i];
		end
	end

	sha256sh_round u_round (
		.vars      (vars_q),
		.win       (win_w),
		.sched_msg (round_q[5:4] == 2'b00),
		.k         (K_TAB[round_q]),
		.vars_nxt  (vars_nxt),
		.wt        (wt)
	);

	always_ff @(posedge clk) begin
		if (ctl.load || busy_q) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= ctl.load ? ctl.word : wt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			vars_q <= chain;
		end else if (busy_q) begin
			vars_q <= vars_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= IV[i];
			end
		end else if (ctl.reinit) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= IV[i];
			end
		end else if (add_q) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + vars_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
			busy_q  <= 1'b0;
			add_q   <= 1'b0;
		end else begin
			add_q <= 1'b0;
			if (ctl.start) begin
				round_q <= '0;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == LAST_ROUND) begin
					busy_q <= 1'b0;
					add_q  <= 1'b1;
				end
			end
		end
	end

	assign sts.busy = busy_q | add_q;
	assign sts.done = add_q;

endmodule

>>> rtl/core/sha256_stream_hasher.sv
// sha-256 stream hasher top level: byte packing, padding sequencer and digest output
// a byte is taken while the hasher is idle; the 64th byte of a block starts 64 rounds on one round unit
// plus one chaining add, and each full block holds the input off until that add is done
// a final byte then pads one byte per cycle (9 to 72 pad bytes, pausing while each padded block
// is compressed) and the eight digest words follow, one per cycle when taken
// reset (arst_n low) returns the chaining words to the initial hash values and clears counts
module sha256_stream_hasher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_ready,
	input  sha256sh_pkg::msg_t  msg,
	output logic                dig_valid,
	input  logic                dig_ready,
	output sha256sh_pkg::dig_t  dig
);
	import sha256sh_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PAD  = 2'd1;
	localparam logic [1:0] ST_COMP = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]  state_q, state_nxt;
	logic [5:0]  fill_q;
	logic [23:0] acc_q;
	logic [60:0] total_q;
	logic [2:0]  idx_q;
	logic        pad_q, sent_q, len_q;
	logic        accept, push, lenmode, dig_take;
	logic [7:0]  push_byte, pad_byte;
	logic [63:0] len_bits;
	core_ctl_t   ctl;
	core_sts_t   sts;
	words8_t     chain;

	assign msg_ready = (state_q == ST_IDLE);
	assign accept    = msg_valid & msg_ready;
	assign dig_valid = (state_q == ST_OUT);
	assign dig_take  = dig_valid & dig_ready;

	always_comb begin
		lenmode   = len_q | (sent_q & (fill_q == LEN_POS));
		len_bits  = {total_q, 3'b000} << {fill_q[2:0], 3'b000};
		pad_byte  = !sent_q ? PAD_MARK : (lenmode ? len_bits[63:56] : 8'h00);
		push      = accept | (state_q == ST_PAD);
		push_byte = (state_q == ST_PAD) ? pad_byte : msg.data_byte;
		ctl.load   = push & (fill_q[1:0] == 2'b11);
		ctl.word   = {acc_q, push_byte};
		ctl.start  = push & (fill_q == LAST_FILL);
		ctl.reinit = dig_take & (idx_q == LAST_IDX);
	end

	sha256sh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.chain  (chain)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (ctl.start) begin
						state_nxt = ST_COMP;
					end else if (msg.last) begin
						state_nxt = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (ctl.start) begin
					state_nxt = ST_COMP;
				end
			end
			ST_COMP: begin
				if (sts.done) begin
					priority if (len_q) begin
						state_nxt = ST_OUT;
					end else if (pad_q) begin
						state_nxt = ST_PAD;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_OUT: begin
				if (ctl.reinit) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			acc_q <= {acc_q[15:0], push_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			total_q <= '0;
			idx_q   <= '0;
			pad_q   <= 1'b0;
			sent_q  <= 1'b0;
			len_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (ctl.reinit) begin
				total_q <= '0;
			end else if (accept) begin
				total_q <= total_q + 61'd1;
			end
			if (accept && msg.last) begin
				pad_q <= 1'b1;
			end
			if (state_q == ST_PAD) begin
				sent_q <= 1'b1;
				len_q  <= lenmode;
			end
			if (ctl.reinit) begin
				pad_q  <= 1'b0;
				sent_q <= 1'b0;
				len_q  <= 1'b0;
			end
			if (dig_take) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	assign dig.digest_word = chain[idx_q];
	assign dig.word_index  = idx_q;
	assign dig.last_word   = (idx_q == LAST_IDX);

endmodule

>>> rtl/core/sha256sh_checker.sv
// port-level checker for the sha-256 stream hasher and its bind
module sha256sh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               msg_valid,
	input logic               msg_ready,
	input sha256sh_pkg::msg_t msg,
	input logic               dig_valid,
	input logic               dig_ready,
	input sha256sh_pkg::dig_t dig
);
	import sha256sh_pkg::*;

	// digest transaction held until taken
	a_dig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> dig_valid && $stable(dig))
		else $error("digest transaction changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_ready && dig_valid))
		else $error("input taken while digest pending");

	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_ready && !dig.last_word |=>
		dig_valid && dig.word_index == $past(dig.word_index) + 3'd1)
		else $error("digest words out of order");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> dig.last_word == (dig.word_index == LAST_IDX))
		else $error("last word flag mismatch");

	a_final_stall: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready && msg.last |=> !msg_ready)
		else $error("input taken right after final byte");

endmodule

bind sha256_stream_hasher sha256sh_checker u_checker (.*);

>>> tb/sv/sha256_digest_checker.sv
// checker for the sha-256 stream hasher: byte-level hash predictor and digest word compare
module sha256_digest_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               msg_valid,
	input  logic               msg_ready,
	input  sha256sh_pkg::msg_t msg,
	input  logic               dig_valid,
	input  logic               dig_ready,
	input  sha256sh_pkg::dig_t dig,
	output int                 errors,
	output int                 pending,
	output int                 words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int LEN_SLOT = 56;
	localparam int BLOCK_BYTES = 64;
	localparam int DIGEST_WORDS = 8;

	localparam logic [31:0] START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	logic [31:0] chain [8];
	logic [7:0]  blk_buf [64];
	int          blk_fill;
	logic [60:0] msg_bytes;
	sha256sh_pkg::dig_t expected_digests [$];

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
		for (i = 16; i < 64; i++)
			w[i] = w[i-16] + w[i-7]
				+ (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_CONST[i] + w[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endtask

	task automatic absorb_byte(input logic [7:0] value);
		blk_buf[blk_fill] = value;
		blk_fill++;
		if (blk_fill == BLOCK_BYTES) begin
			compress_block();
			blk_fill = 0;
		end
	endtask

	task automatic restart_message();
		chain = START_HASH;
		msg_bytes = '0;
		blk_fill = 0;
	endtask

	task automatic hash_msg_byte(input sha256sh_pkg::msg_t m);
		logic [63:0] bit_len;
		sha256sh_pkg::dig_t word;
		int i;
		msg_bytes = msg_bytes + 61'd1;
		absorb_byte(m.data_byte);
		if (m.last) begin
			bit_len = {msg_bytes, 3'b000};
			absorb_byte(PAD_BYTE);
			while (blk_fill != LEN_SLOT)
				absorb_byte(8'h00);
			for (i = 7; i >= 0; i--)
				absorb_byte(bit_len[8*i +: 8]);
			for (i = 0; i < DIGEST_WORDS; i++) begin
				word.digest_word = chain[i];
				word.word_index = 3'(i);
				word.last_word = (i == DIGEST_WORDS - 1);
				expected_digests = {expected_digests, word};
			end
			restart_message();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sha256sh_pkg::dig_t want;
		if (!arst_n) begin
			restart_message();
			expected_digests.delete();
			errors = 0;
			words_checked = 0;
		end else begin
			if (dig_valid && dig_ready) begin
				if (expected_digests.size() == 0) begin
					$error("unexpected digest transaction: digest_word %h word_index %0d",
						dig.digest_word, dig.word_index);
					errors++;
				end else begin
					want = expected_digests.pop_front();
					words_checked++;
					if (dig.digest_word !== want.digest_word) begin
						$error("digest_word: expected %h, got %h", want.digest_word, dig.digest_word);
						errors++;
					end
					if (dig.word_index !== want.word_index) begin
						$error("word_index: expected %0d, got %0d", want.word_index, dig.word_index);
						errors++;
					end
					if (dig.last_word !== want.last_word) begin
						$error("last_word: expected %0b, got %0b", want.last_word, dig.last_word);
						errors++;
					end
				end
			end
			if (msg_valid && msg_ready)
				hash_msg_byte(msg);
		end
		pending = expected_digests.size();
	end

endmodule

>>> tb/sv/tb_sha256_stream_hasher.sv
// testbench top for the sha-256 stream hasher: clock, reset, message stimulus and verdict
module tb_sha256_stream_hasher;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 170;
	localparam int MIN_MESSAGES = 12;
	localparam int PRESSURE_CYCLES = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam int BOUNDARY_LENS [6] = '{55, 56, 57, 63, 64, 65};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic msg_valid = 1'b0;
	logic msg_ready;
	sha256sh_pkg::msg_t msg = '0;
	logic dig_valid;
	logic dig_ready = 1'b0;
	sha256sh_pkg::dig_t dig;

	int errors;
	int pending;
	int words_checked;
	int bytes_sent = 0;
	int msgs_sent = 0;
	int cycle_count = 0;
	int send_odds = 0;
	logic calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sha256_stream_hasher DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig       (dig)
	);

	sha256_digest_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.msg_valid     (msg_valid),
		.msg_ready     (msg_ready),
		.msg           (msg),
		.dig_valid     (dig_valid),
		.dig_ready     (dig_ready),
		.dig           (dig),
		.errors        (errors),
		.pending       (pending),
		.words_checked (words_checked)
	);

	task automatic send_byte(input logic [7:0] value, input logic fin);
		if (!calm && $urandom_range(0, 7) < send_odds) begin
			msg_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		msg <= sha256sh_pkg::msg_t'{value, fin};
		msg_valid <= 1'b1;
		@(posedge clk);
		while (!msg_ready)
			@(posedge clk);
		bytes_sent++;
		if (fin)
			msgs_sent++;
		@(negedge clk);
	endtask

	task automatic send_message(input int len);
		int k;
		send_odds = $urandom_range(0, 4);
		for (k = 1; k <= len; k++)
			send_byte(8'($urandom_range(0, 255)), k == len);
	endtask

	// digest sink: one long hold-off first, then random stalls in phases
	initial begin
		int hold, n, idle_odds, phase_left;
		phase_left = 0;
		idle_odds = 0;
		wait (arst_n);
		@(negedge clk);
		for (hold = 0; hold < PRESSURE_CYCLES; hold++)
			@(negedge clk);
		forever begin
			if (phase_left <= 0) begin
				idle_odds = $urandom_range(0, 3);
				phase_left = 64;
			end
			if (!calm && $urandom_range(0, 7) < idle_odds) begin
				dig_ready <= 1'b0;
				n = $urandom_range(1, 16);
				repeat (n) @(negedge clk);
				phase_left -= n;
			end else begin
				dig_ready <= 1'b1;
				@(negedge clk);
				phase_left--;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_sha256_stream_hasher: done, errors");
		$finish;
	end

	initial begin
		int len;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single-byte messages at both extremes, the three-byte text vector, then a two-byte and a three-byte message
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h63, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7f, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(8'h01, 1'b1);

		// mostly short messages, some sized around the length slot and block edge
		while (bytes_sent < RANDOM_BYTES || msgs_sent < MIN_MESSAGES) begin
			if ($urandom_range(0, 9) < 3)
				len = BOUNDARY_LENS[$urandom_range(0, 5)];
			else
				len = $urandom_range(1, 20);
			send_message(len);
		end

		calm = 1'b1;
		repeat (3) send_message($urandom_range(1, 40));
		msg_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("hashed %0d messages from %0d bytes, %0d digest words compared",
			msgs_sent, bytes_sent, words_checked);
		$display("lengths spanned padding that fits, spills to a second block and whole blocks");
		if (errors == 0)
			$display("tb_sha256_stream_hasher: done, clean");
		else
			$display("tb_sha256_stream_hasher: done, errors");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/sha256sh_pkg.sv
rtl/core/sha256sh_round.sv
rtl/core/sha256sh_core.sv
rtl/core/sha256_stream_hasher.sv
rtl/core/sha256sh_checker.sv
tb/sv/sha256_digest_checker.sv
tb/sv/tb_sha256_stream_hasher.sv
